// ===== hdl/ovl_pkg.sv =====
// shared types and codes for the ordered value list unit
package ovl_pkg;

    // operation codes carried in the input item
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } ovl_status_t;

    // one result item as it leaves the block
    typedef struct packed {
        logic [4:0]  count;
        logic [4:0]  position;
        ovl_status_t status;
    } ovl_result_t;

endpackage

// ===== hdl/ordered_value_list_unit.sv =====
// ordered value list unit: linked list of 32-bit values in a node memory
//
// usage:
//   s_* carries one command item per handshake: append, remove first match
//   or search first match of a 32-bit value; m_* returns one result item
//   per command with status, 1-based position of the match and the count.
//   values are kept in insertion order as a circular doubly linked list in
//   one node memory (value, next link, prev link per node).
// operation:
//   the block works on one item at a time; s_tready is high while idle.
//   append goes through the link step, then tail and head steps as the list
//   needs, with a pop step first when a freed node is reused; search and
//   remove walk from the head, one node memory read a cycle, to the match,
//   and remove then relinks the neighbours. a miss walks all held nodes.
// reset:
//   the list comes up empty at once; the node memory needs no clearing
//   since only nodes in the list or in the free pool are ever read.
// stalls:
//   a finished result sits in the output register; the next item is taken
//   meanwhile and waits at its end until the output register frees up.
module ordered_value_list_unit
    import ovl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // cmd[1:0], value[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // status[1:0], position[6:2], count[11:7], zero pad
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = 32 + 2 * IW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_LINK,
        S_TAIL,
        S_HEAD,
        S_WALK,
        S_RPREV,
        S_RNEXT,
        S_FINISH
    } state_t;

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] fill_reg, fill_next;          // nodes handed out at least once
    logic [CW-1:0] free_cnt_reg, free_cnt_next;  // nodes on the free chain
    logic [IW-1:0] free_head_reg, free_head_next;

    // per-item working registers
    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   value_reg, value_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [IW-1:0] node_reg, node_next;
    logic [IW-1:0] lnext_reg, lnext_next;        // successor of removed node
    logic [IW-1:0] lprev_reg, lprev_next;        // predecessor of removed node
    ovl_status_t   status_reg, status_next;

    // node memory port
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [WW-1:0] mem_rdata;
    logic [31:0]   rd_value;
    logic [IW-1:0] rd_next;
    logic [IW-1:0] rd_prev;

    // result path
    logic          res_load;
    logic          out_can_load;
    ovl_result_t   result;
    logic [CW+4:0] pos_wide;
    logic [CW+4:0] count_wide;

    assign rd_value = mem_rdata[WW-1:2*IW];
    assign rd_next  = mem_rdata[2*IW-1:IW];
    assign rd_prev  = mem_rdata[IW-1:0];

    assign s_tready = (state_reg == S_IDLE);

    // position and count leave as 5-bit fields
    assign pos_wide        = {5'b0, pos_reg};
    assign count_wide      = {5'b0, count_reg};
    assign result.status   = status_reg;
    assign result.position = pos_wide[4:0];
    assign result.count    = count_wide[4:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        free_cnt_next  = free_cnt_reg;
        free_head_next = free_head_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        node_next      = node_reg;
        lnext_next     = lnext_reg;
        lprev_next     = lprev_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = {value_reg, node_reg, node_reg};
        mem_raddr      = cur_reg;
        res_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tdata[1:0];
                    value_next  = s_tdata[33:2];
                    pos_next    = '0;
                    status_next = ST_OK;
                    case (s_tdata[1:0]) inside
                        CMD_APPEND:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FINISH;
                            end
                            else if (free_cnt_reg != '0)
                            begin
                                // reuse a freed node, fetch its chain link
                                node_next  = free_head_reg;
                                mem_raddr  = free_head_reg;
                                state_next = S_POP;
                            end
                            else
                            begin
                                node_next  = fill_reg[IW-1:0];
                                fill_next  = fill_reg + 1'b1;
                                state_next = S_LINK;
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                mem_raddr  = head_reg;
                                pos_next   = CW'(1);
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                free_head_next = rd_next;
                free_cnt_next  = free_cnt_reg - 1'b1;
                state_next     = S_LINK;
            end
            S_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = node_reg;
                if (count_reg == '0)
                begin
                    mem_wdata  = {value_reg, node_reg, node_reg};
                    head_next  = node_reg;
                    tail_next  = node_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_wdata  = {value_reg, head_reg, tail_reg};
                    mem_raddr  = tail_reg;
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // old tail points forward to the new node
                mem_we    = 1'b1;
                mem_waddr = tail_reg;
                if (tail_reg == head_reg)
                begin
                    mem_wdata  = {rd_value, node_reg, node_reg};
                    tail_next  = node_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_wdata  = {rd_value, node_reg, rd_prev};
                    mem_raddr  = head_reg;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                // head points back to the new tail
                mem_we     = 1'b1;
                mem_waddr  = head_reg;
                mem_wdata  = {rd_value, rd_next, node_reg};
                tail_next  = node_reg;
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_WALK:
            begin
                if (rd_value == value_reg)
                begin
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        node_next      = cur_reg;
                        lnext_next     = rd_next;
                        lprev_next     = rd_prev;
                        // push the node onto the free chain
                        mem_we         = 1'b1;
                        mem_waddr      = cur_reg;
                        mem_wdata      = {rd_value, free_head_reg, rd_prev};
                        free_head_next = cur_reg;
                        free_cnt_next  = free_cnt_reg + 1'b1;
                        if (count_reg == CW'(1))
                        begin
                            count_next = '0;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            mem_raddr  = rd_prev;
                            state_next = S_RPREV;
                        end
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (pos_reg == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    pos_next    = '0;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cur_next  = rd_next;
                    mem_raddr = rd_next;
                    pos_next  = pos_reg + 1'b1;
                end
            end
            S_RPREV:
            begin
                mem_we    = 1'b1;
                mem_waddr = lprev_reg;
                if (lprev_reg == lnext_reg)
                begin
                    // one neighbor left: it links to itself both ways
                    mem_wdata  = {rd_value, lnext_reg, lprev_reg};
                    count_next = count_reg - 1'b1;
                    if (head_reg == node_reg)
                    begin
                        head_next = lnext_reg;
                    end
                    if (tail_reg == node_reg)
                    begin
                        tail_next = lprev_reg;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_wdata  = {rd_value, lnext_reg, rd_prev};
                    mem_raddr  = lnext_reg;
                    state_next = S_RNEXT;
                end
            end
            S_RNEXT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lnext_reg;
                mem_wdata  = {rd_value, rd_next, lprev_reg};
                count_next = count_reg - 1'b1;
                if (head_reg == node_reg)
                begin
                    head_next = lnext_reg;
                end
                if (tail_reg == node_reg)
                begin
                    tail_next = lprev_reg;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold here while the previous result is still unread
                if (out_can_load)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            free_cnt_reg  <= '0;
            free_head_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            free_cnt_reg  <= free_cnt_next;
            free_head_reg <= free_head_next;
        end
    end

    // working registers hold payload only
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        node_reg   <= node_next;
        lnext_reg  <= lnext_next;
        lprev_reg  <= lprev_next;
        status_reg <= status_next;
    end

    ovl_node_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WW)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ovl_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .result   (result),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/ovl_node_ram.sv =====
// node memory: one write port, one read port, registered read data
module ovl_node_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ovl_out_stage.sv =====
// output register for result items
module ovl_out_stage
    import ovl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  ovl_result_t result,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], position[6:2], count[11:7], zero pad
);

    logic        valid_reg;
    ovl_result_t data_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0, data_reg.count, data_reg.position, data_reg.status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule
